// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
// GS_ASSERT expects signals named clk and rst_n in the enclosing scope; GS_ASSERT_ALWAYS expects only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define GS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define GS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/gs1d_pkg.sv -----
// ----------------------------------------------------------------------------
// gs1d_pkg
// Constants, kernel tap ROM and helper functions for the 1-D Gaussian
// smoothing block.
// ----------------------------------------------------------------------------
package gs1d_pkg;

    // Default configuration of the top level.
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_MAX_TAPS     = 21;
    localparam int DEF_MAX_SIGMA    = 3;

    // Fixed field widths.
    localparam int SIGMA_W = 2;
    localparam int TAP_W   = 12;
    localparam int NORM_W  = 13;
    localparam int OFF_W   = 4;
    localparam int CNT_W   = 5;

    // Sequence sample counter saturates here.
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

    // Largest sigma held in the tap ROM.
    localparam int ROM_SIGMAS = 3;

    // Kernel tap at a given offset from the center.
    function automatic logic [TAP_W-1:0] tap_value(input logic [SIGMA_W-1:0] sig,
                                                   input logic [OFF_W-1:0] off);
        logic [TAP_W-1:0] t;
        t = '0;
        case (sig)
            2'd1:
            begin
                case (off)
                    4'd0:    t = 12'd2981;
                    4'd1:    t = 12'd1808;
                    4'd2:    t = 12'd403;
                    4'd3:    t = 12'd33;
                    4'd4:    t = 12'd1;
                    default: t = '0;
                endcase
            end
            2'd2:
            begin
                case (off)
                    4'd0:    t = 12'd457;
                    4'd1:    t = 12'd403;
                    4'd2:    t = 12'd277;
                    4'd3:    t = 12'd148;
                    4'd4:    t = 12'd62;
                    4'd5:    t = 12'd20;
                    4'd6:    t = 12'd5;
                    4'd7:    t = 12'd1;
                    default: t = '0;
                endcase
            end
            2'd3:
            begin
                case (off)
                    4'd0:    t = 12'd259;
                    4'd1:    t = 12'd245;
                    4'd2:    t = 12'd207;
                    4'd3:    t = 12'd157;
                    4'd4:    t = 12'd106;
                    4'd5:    t = 12'd65;
                    4'd6:    t = 12'd35;
                    4'd7:    t = 12'd17;
                    4'd8:    t = 12'd7;
                    4'd9:    t = 12'd3;
                    4'd10:   t = 12'd1;
                    default: t = '0;
                endcase
            end
            default: t = '0;
        endcase
        return t;
    endfunction

    // Sum of all 2L+1 taps of a kernel.
    function automatic logic [NORM_W-1:0] tap_sum(input logic [SIGMA_W-1:0] sig);
        logic [NORM_W-1:0] s;
        case (sig)
            2'd1:    s = 13'd7471;
            2'd2:    s = 13'd2289;
            2'd3:    s = 13'd1945;
            default: s = 13'd1;
        endcase
        return s;
    endfunction

    // Largest usable sigma: bounded by the ROM, by max_sigma, and by the
    // number of taps the window can hold.
    function automatic int sigma_limit(input int max_sigma, input int max_taps);
        int s;
        s = (max_sigma < ROM_SIGMAS) ? max_sigma : ROM_SIGMAS;
        for (int n = 0; n < ROM_SIGMAS; n++)
        begin
            if (s > 1 && (6 * s + 3) > max_taps)
                s = s - 1;
        end
        return s;
    endfunction

endpackage

// ----- design/gaussian_smooth_1d_top.sv -----
// ----------------------------------------------------------------------------
// gaussian_smooth_1d_top
// Streaming 1-D Gaussian smoothing with replicated borders and rounded
// normalization.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the sample channel (sample, last) and smoothed values
// leave on the result channel (smoothed, end_of_sequence); a transfer takes
// place when valid is high and stall is low. sigma_select is to be written
// by the user through sigma_select_wr_en / sigma_select_wr_data only while
// the block is idle; the block itself does not enforce this. With half width
// L = 3*sigma + 1, output j leaves once input j+L has been taken; the input
// marked last flushes the remaining outputs, so n inputs give n outputs, the
// final one flagged by end_of_sequence.
// Each output is formed by tap accumulation through the single window memory
// read port and multiplier, then by the bit-serial divider, and is then
// loaded into the output register. No input is taken until the block is
// idle again, and an input that produces no output leaves it idle. The last
// input produces up to L+1 outputs, each formed the same way in turn.
// Reset clears the sample count and sets sigma to 1; the window memory needs
// no clearing because the first sample of a sequence stands in for all older
// entries. A stalled result is held in the output register; the next input is
// still taken, but a new result waits until the register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gaussian_smooth_1d_top #(
    parameter int SAMPLE_WIDTH = gs1d_pkg::DEF_SAMPLE_WIDTH,
    parameter int MAX_TAPS     = gs1d_pkg::DEF_MAX_TAPS,
    parameter int MAX_SIGMA    = gs1d_pkg::DEF_MAX_SIGMA
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sigma_select_wr_en,
    input  logic [gs1d_pkg::SIGMA_W-1:0]          sigma_select_wr_data,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample,
    input  logic                                  last,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        smoothed,
    output logic                                  end_of_sequence
);

    localparam int I_W     = $clog2(MAX_TAPS);
    localparam int SIG_LIM = gs1d_pkg::sigma_limit(MAX_SIGMA, MAX_TAPS);
    localparam int PROD_W  = SAMPLE_WIDTH + gs1d_pkg::TAP_W + 1;
    localparam int ACC_W   = PROD_W + 5;
    localparam int DIV_W   = ACC_W + 1;
    localparam int K_W     = $clog2(SAMPLE_WIDTH);
    localparam int SIG_W   = gs1d_pkg::SIGMA_W;
    localparam int CNT_W   = gs1d_pkg::CNT_W;
    localparam int OFF_W   = gs1d_pkg::OFF_W;

    localparam logic [SAMPLE_WIDTH-1:0] POS_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] NEG_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DIV, ST_OUT} state_t;
    typedef enum logic [1:0] {SRC_MEM, SRC_FIRST, SRC_LAST} src_t;

    // Control registers.
    state_t                         state_reg, state_next;
    logic [SIG_W-1:0]               sigma_reg, sigma_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [I_W-1:0]                 hp_reg, hp_next;
    logic                           last_reg, last_next;
    logic [SIG_W-1:0]               sig_reg, sig_next;
    logic [I_W-1:0]                 half_reg, half_next;
    logic [I_W-1:0]                 m_reg, m_next;
    logic [I_W-1:0]                 i_reg, i_next;
    logic                           issue_done_reg, issue_done_next;
    logic                           valid_a_reg, valid_a_next;
    logic                           valid_b_reg, valid_b_next;
    logic [K_W-1:0]                 k_reg, k_next;
    logic                           result_valid_reg, result_valid_next;

    // Datapath registers.
    logic signed [SAMPLE_WIDTH-1:0] first_reg, first_next;
    logic signed [SAMPLE_WIDTH-1:0] last_x_reg, last_x_next;
    src_t                           src_a_reg, src_a_next;
    logic [gs1d_pkg::TAP_W-1:0]     tap_a_reg, tap_a_next;
    logic signed [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic [DIV_W-1:0]               rem_reg, rem_next;
    logic [DIV_W-1:0]               dsh_reg, dsh_next;
    logic [SAMPLE_WIDTH-1:0]        q_reg, q_next;
    logic                           neg_reg, neg_next;
    logic signed [SAMPLE_WIDTH-1:0] smoothed_reg, smoothed_next;
    logic                           eos_reg, eos_next;

    // Window memory.
    logic signed [SAMPLE_WIDTH-1:0] win_mem [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic                           mem_we;
    logic [I_W-1:0]                 rd_addr;

    // Helper signals.
    logic [SIG_W-1:0]               sig_eff;
    logic [I_W-1:0]                 half_eff;
    logic [CNT_W-1:0]               cnt_inc;
    logic [I_W-1:0]                 hp_inc;
    logic [I_W-1:0]                 age;
    logic [I_W-1:0]                 tap_off;
    logic [I_W:0]                   addr_wrap;
    logic signed [SAMPLE_WIDTH-1:0] x_b;
    logic [ACC_W-1:0]               acc_mag;
    logic [gs1d_pkg::NORM_W-1:0]    norm;
    logic [SAMPLE_WIDTH-1:0]        q_clamped;

    // Effective sigma and half width from the configuration register.
    always_comb
    begin
        sig_eff = (sigma_reg == '0) ? SIG_W'(1) : sigma_reg;
        if (sig_eff > SIG_W'(SIG_LIM))
            sig_eff = SIG_W'(SIG_LIM);
        half_eff = I_W'({sig_eff, 1'b0}) + I_W'(sig_eff) + I_W'(1);
    end

    assign cnt_inc = (cnt_reg < gs1d_pkg::COUNT_MAX) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign hp_inc  = (hp_reg == I_W'(MAX_TAPS - 1)) ? '0 : hp_reg + I_W'(1);

    // Window position i maps to sample age i - m once m flush copies of the
    // last sample are in front; ages past the sequence start read the first.
    assign age       = i_reg - m_reg;
    assign addr_wrap = {1'b0, hp_reg} + (I_W + 1)'(MAX_TAPS) - {1'b0, age};
    assign rd_addr   = (hp_reg >= age) ? hp_reg - age : addr_wrap[I_W-1:0];
    assign tap_off   = (i_reg > half_reg) ? i_reg - half_reg : half_reg - i_reg;

    // Sample selected for the tap now in the multiply stage.
    always_comb
    begin
        case (src_a_reg)
            SRC_MEM:   x_b = rd_data_reg;
            SRC_FIRST: x_b = first_reg;
            SRC_LAST:  x_b = last_x_reg;
            default:   x_b = first_reg;
        endcase
    end

    assign norm    = gs1d_pkg::tap_sum(sig_reg);
    assign acc_mag = (acc_reg < 0) ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    // Saturate the rounded magnitude to the signed sample range.
    always_comb
    begin
        if (!neg_reg && q_reg > POS_MAX)
            q_clamped = POS_MAX;
        else if (neg_reg && q_reg > NEG_MIN)
            q_clamped = NEG_MIN;
        else
            q_clamped = q_reg;
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next        = state_reg;
        sigma_next        = sigma_reg;
        cnt_next          = cnt_reg;
        hp_next           = hp_reg;
        last_next         = last_reg;
        sig_next          = sig_reg;
        half_next         = half_reg;
        m_next            = m_reg;
        i_next            = i_reg;
        issue_done_next   = issue_done_reg;
        valid_a_next      = 1'b0;
        valid_b_next      = 1'b0;
        k_next            = k_reg;
        result_valid_next = result_valid_reg;
        first_next        = first_reg;
        last_x_next       = last_x_reg;
        src_a_next        = src_a_reg;
        tap_a_next        = tap_a_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        rem_next          = rem_reg;
        dsh_next          = dsh_reg;
        q_next            = q_reg;
        neg_next          = neg_reg;
        smoothed_next     = smoothed_reg;
        eos_next          = eos_reg;
        mem_we            = 1'b0;

        // The result register empties on a transfer.
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        if (sigma_select_wr_en)
            sigma_next = sigma_select_wr_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    mem_we      = 1'b1;
                    hp_next     = hp_inc;
                    cnt_next    = cnt_inc;
                    last_x_next = sample;
                    last_next   = last;
                    sig_next    = sig_eff;
                    half_next   = half_eff;
                    if (cnt_reg == '0)
                        first_next = sample;
                    i_next          = '0;
                    issue_done_next = 1'b0;
                    acc_next        = '0;
                    if (cnt_inc > CNT_W'(half_eff))
                    begin
                        m_next     = '0;
                        state_next = ST_MAC;
                    end
                    else if (last)
                    begin
                        m_next     = half_eff - I_W'(cnt_inc) + I_W'(1);
                        state_next = ST_MAC;
                    end
                end
            end

            ST_MAC:
            begin
                // Issue: pick the source and tap for window position i.
                if (!issue_done_reg)
                begin
                    valid_a_next = 1'b1;
                    if (i_reg < m_reg)
                        src_a_next = SRC_LAST;
                    else if (CNT_W'(age) < cnt_reg)
                        src_a_next = SRC_MEM;
                    else
                        src_a_next = SRC_FIRST;
                    tap_a_next = gs1d_pkg::tap_value(sig_reg, OFF_W'(tap_off));
                    if (i_reg == I_W'({half_reg, 1'b0}))
                        issue_done_next = 1'b1;
                    else
                        i_next = i_reg + I_W'(1);
                end
                // Multiply.
                if (valid_a_reg)
                begin
                    valid_b_next = 1'b1;
                    prod_next = PROD_W'(x_b) *
                                PROD_W'($signed({1'b0, tap_a_reg}));
                end
                // Accumulate.
                if (valid_b_reg)
                    acc_next = acc_reg + ACC_W'(prod_reg);
                // Pipeline drained: set up the rounding division.
                if (issue_done_reg && !valid_a_reg && !valid_b_reg)
                begin
                    neg_next   = acc_reg < 0;
                    rem_next   = {acc_mag, 1'b0} + DIV_W'(norm);
                    dsh_next   = DIV_W'({norm, 1'b0}) << (SAMPLE_WIDTH - 1);
                    q_next     = '0;
                    k_next     = K_W'(SAMPLE_WIDTH - 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // One quotient bit per cycle, restoring.
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[SAMPLE_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[SAMPLE_WIDTH-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                k_next   = k_reg - K_W'(1);
                if (k_reg == '0)
                    state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    smoothed_next     = neg_reg ? -$signed(q_clamped) : $signed(q_clamped);
                    eos_next          = last_reg && (m_reg == half_reg);
                    if (last_reg && m_reg < half_reg)
                    begin
                        m_next          = m_reg + I_W'(1);
                        i_next          = '0;
                        issue_done_next = 1'b0;
                        acc_next        = '0;
                        state_next      = ST_MAC;
                    end
                    else
                    begin
                        if (last_reg)
                            cnt_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sigma_reg        <= SIG_W'(1);
            cnt_reg          <= '0;
            hp_reg           <= '0;
            last_reg         <= 1'b0;
            sig_reg          <= SIG_W'(1);
            half_reg         <= I_W'(4);
            m_reg            <= '0;
            i_reg            <= '0;
            issue_done_reg   <= 1'b0;
            valid_a_reg      <= 1'b0;
            valid_b_reg      <= 1'b0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
            smoothed_reg     <= '0;
            eos_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sigma_reg        <= sigma_next;
            cnt_reg          <= cnt_next;
            hp_reg           <= hp_next;
            last_reg         <= last_next;
            sig_reg          <= sig_next;
            half_reg         <= half_next;
            m_reg            <= m_next;
            i_reg            <= i_next;
            issue_done_reg   <= issue_done_next;
            valid_a_reg      <= valid_a_next;
            valid_b_reg      <= valid_b_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
            smoothed_reg     <= smoothed_next;
            eos_reg          <= eos_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        last_x_reg   <= last_x_next;
        src_a_reg    <= src_a_next;
        tap_a_reg    <= tap_a_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        q_reg        <= q_next;
        neg_reg      <= neg_next;
    end

    // Window memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            win_mem[hp_inc] <= sample;
        rd_data_reg <= win_mem[rd_addr];
    end

    assign sample_stall    = (state_reg != ST_IDLE);
    assign result_valid    = result_valid_reg;
    assign smoothed        = smoothed_reg;
    assign end_of_sequence = eos_reg;

    // Assertions.
    `GS_ASSERT(a_mac_has_samples, (state_reg == ST_MAC) |-> (cnt_reg != '0),
               "Accumulation started without a sample in the sequence")
    `GS_ASSERT(a_flush_in_range, (state_reg == ST_MAC) |-> (m_reg <= half_reg),
               "Flush shift count beyond half width")
    `GS_ASSERT(a_pipe_drained, (state_reg == ST_DIV) |-> (!valid_a_reg && !valid_b_reg),
               "Division started with taps still in flight")
    `GS_ASSERT(a_load_from_out, $rose(result_valid_reg) |-> $past(state_reg == ST_OUT),
               "Result register loaded outside the output step")
    `GS_ASSERT(a_half_nonzero, half_reg >= I_W'(4),
               "Kernel half width below its minimum")

endmodule
